// ===== rtl/tbrl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Token bucket rate limiter - shared types and constants
// Field widths, item mode codes, reset rate and the structs passed between
// the bucket datapath, the elapsed-time tracker and the response buffer.
// ----------------------------------------------------------------------------
package tbrl_pkg;

   localparam int TOKEN_W = 16;

   localparam logic MODE_TICK    = 1'b0;
   localparam logic MODE_REQUEST = 1'b1;

   localparam logic [TOKEN_W-1:0] RESET_RATE = 16'd100;

   typedef logic [TOKEN_W-1:0] token_type;

   typedef struct packed {
      logic      tick;
      logic      clear;
      logic      load;
      token_type load_rate;
   } elapsed_ctl_type;

   typedef struct packed {
      logic      granted;
      token_type tokens_left;
   } rsp_type;

endpackage : tbrl_pkg
`default_nettype wire

// ===== rtl/tbrl_elapsed.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Elapsed-time tracker
// Counts millisecond ticks up to TICKS_PER_SECOND and keeps the running
// product elapsed * rate, so the refill amount is one reciprocal multiply.
// ----------------------------------------------------------------------------
module tbrl_elapsed
   import tbrl_pkg::*;
#(
   parameter int TICKS_PER_SECOND = 1000
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire elapsed_ctl_type ctl,
   input  wire token_type       rate,
   output token_type            added
);

   localparam int EL_W    = $clog2(TICKS_PER_SECOND + 1);
   localparam int PROD_W  = EL_W + TOKEN_W;
   localparam int SHIFT   = PROD_W + $clog2(TICKS_PER_SECOND);
   localparam int RECIP_W = PROD_W + 1;
   localparam int WIDE_W  = PROD_W + RECIP_W;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
   localparam logic [EL_W-1:0]    EL_MAX = EL_W'(TICKS_PER_SECOND);

   logic [EL_W-1:0]   elapsed_ff, elapsed_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [WIDE_W-1:0] wide;

   always_comb begin
      elapsed_in = elapsed_ff;
      prod_in    = prod_ff;
      if (ctl.load) begin
         prod_in = PROD_W'(elapsed_ff) * PROD_W'(ctl.load_rate);
      end else if (ctl.clear) begin
         elapsed_in = '0;
         prod_in    = '0;
      end else if (ctl.tick && (elapsed_ff < EL_MAX)) begin
         elapsed_in = elapsed_ff + EL_W'(1);
         prod_in    = prod_ff + PROD_W'(rate);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         prod_ff    <= '0;
      end else begin
         elapsed_ff <= elapsed_in;
         prod_ff    <= prod_in;
      end
   end

   // floor(prod / TICKS_PER_SECOND), exact over the whole product range
   assign wide  = WIDE_W'(prod_ff) * WIDE_W'(RECIP);
   assign added = wide[SHIFT +: TOKEN_W];

endmodule : tbrl_elapsed
`default_nettype wire

// ===== rtl/tbrl_bucket.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bucket datapath
// Holds the rate and token count, applies the refill, decides grant or deny
// and forms the response for each request transaction.
// ----------------------------------------------------------------------------
module tbrl_bucket
   import tbrl_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      item_accept,
   input  wire logic      item_mode,
   input  wire token_type item_permits,
   input  wire logic      csr_write,
   input  wire token_type csr_value,
   input  wire token_type added,
   output token_type      rate,
   output elapsed_ctl_type ctl,
   output logic           rsp_push,
   output rsp_type        rsp
);

   token_type          rate_ff, rate_in;
   token_type          token_ff, token_in;
   logic               is_req, is_tick, deny_now, refill_hit, grant;
   logic [TOKEN_W:0]   sum;
   token_type          capped, tok_after;

   assign is_req     = item_accept && (item_mode == MODE_REQUEST);
   assign is_tick    = item_accept && (item_mode == MODE_TICK);
   assign deny_now   = (item_permits == '0) || (rate_ff == '0);
   assign refill_hit = (added != '0);
   assign sum        = {1'b0, token_ff} + {1'b0, added};

   always_comb begin
      capped = token_ff;
      if (refill_hit) begin
         capped = (sum > {1'b0, rate_ff}) ? rate_ff : sum[TOKEN_W-1:0];
      end
   end

   assign grant     = (capped >= item_permits);
   assign tok_after = grant ? (capped - item_permits) : capped;

   always_comb begin
      rate_in  = rate_ff;
      token_in = token_ff;
      if (csr_write) begin
         rate_in  = csr_value;
         token_in = csr_value;
      end else if (is_req && !deny_now) begin
         token_in = tok_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= RESET_RATE;
         token_ff <= RESET_RATE;
      end else begin
         rate_ff  <= rate_in;
         token_ff <= token_in;
      end
   end

   assign rate            = rate_ff;
   assign ctl.tick        = is_tick;
   assign ctl.clear       = is_req && !deny_now && refill_hit;
   assign ctl.load        = csr_write;
   assign ctl.load_rate   = csr_value;
   assign rsp_push        = is_req;
   assign rsp.granted     = !deny_now && grant;
   assign rsp.tokens_left = deny_now ? token_ff : tok_after;

endmodule : tbrl_bucket
`default_nettype wire

// ===== rtl/tbrl_rsp_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response buffer
// Two-entry output queue: a head register plus a skid entry, so requests keep
// flowing while one response waits on the consumer.
// ----------------------------------------------------------------------------
module tbrl_rsp_buf
   import tbrl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   input  wire logic    pop_ready,
   output logic         head_valid,
   output rsp_type      head_data,
   output logic         full
);

   logic    valid0_ff, valid0_in, valid1_ff, valid1_in;
   rsp_type data0_ff, data0_in, data1_ff, data1_in;
   logic    pop;

   assign pop = valid0_ff && pop_ready;

   always_comb begin
      valid0_in = valid0_ff;
      valid1_in = valid1_ff;
      data0_in  = data0_ff;
      data1_in  = data1_ff;
      if (pop && push) begin
         if (valid1_ff) begin
            data0_in = data1_ff;
            data1_in = push_data;
         end else begin
            data0_in = push_data;
         end
      end else if (pop) begin
         data0_in  = data1_ff;
         valid0_in = valid1_ff;
         valid1_in = 1'b0;
      end else if (push) begin
         if (!valid0_ff) begin
            data0_in  = push_data;
            valid0_in = 1'b1;
         end else begin
            data1_in  = push_data;
            valid1_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         valid1_ff <= 1'b0;
      end else begin
         valid0_ff <= valid0_in;
         valid1_ff <= valid1_in;
      end
   end

   always_ff @(posedge clock) begin
      data0_ff <= data0_in;
      data1_ff <= data1_in;
   end

   assign head_valid = valid0_ff;
   assign head_data  = data0_ff;
   assign full       = valid1_ff;

endmodule : tbrl_rsp_buf
`default_nettype wire

// ===== rtl/token_bucket_rate_limiter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Token bucket rate limiter
// Takes one transaction per clock: a millisecond tick (no response) or a
// permit request (one grant/deny response, registered into the output queue). The
// refill elapsed*rate/TICKS_PER_SECOND comes from a running product register
// and one reciprocal multiply, so the bucket update needs no divider.
// Responses pass through a two-entry output queue; req_ready drops only while
// both entries are held. No clearing pass after reset. Writing the rate
// register reloads the bucket full.
// ----------------------------------------------------------------------------
module token_bucket_rate_limiter
   import tbrl_pkg::*;
#(
   parameter int TICKS_PER_SECOND = 1000
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic         req_mode,
   input  wire logic [15:0]  req_permits,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic              rsp_granted,
   output logic [15:0]       rsp_tokens_left,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [15:0]  csr_data
);

   logic            item_accept, csr_write, rsp_push, buf_full;
   token_type       added, rate;
   elapsed_ctl_type ctl;
   rsp_type         rsp_new, rsp_head;

   assign req_ready   = !buf_full;
   assign csr_ready   = 1'b1;
   assign item_accept = req_valid && req_ready;
   assign csr_write   = csr_valid && csr_ready;

   tbrl_elapsed #(
      .TICKS_PER_SECOND(TICKS_PER_SECOND)
   ) u_elapsed (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .rate  (rate),
      .added (added)
   );

   tbrl_bucket u_bucket (
      .clock        (clock),
      .reset        (reset),
      .item_accept  (item_accept),
      .item_mode    (req_mode),
      .item_permits (req_permits),
      .csr_write    (csr_write),
      .csr_value    (csr_data),
      .added        (added),
      .rate         (rate),
      .ctl          (ctl),
      .rsp_push     (rsp_push),
      .rsp          (rsp_new)
   );

   tbrl_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (rsp_push),
      .push_data  (rsp_new),
      .pop_ready  (rsp_ready),
      .head_valid (rsp_valid),
      .head_data  (rsp_head),
      .full       (buf_full)
   );

   assign rsp_granted     = rsp_head.granted;
   assign rsp_tokens_left = rsp_head.tokens_left;

endmodule : token_bucket_rate_limiter
`default_nettype wire

// ===== verif/tb_token_bucket_rate_limiter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token bucket rate limiter - self-checking testbench
// Drives ticks and permit requests through the request channel, and writes
// the rate through the CSR channel while the block is idle. A bucket model
// kept in the bench predicts every grant/deny transaction. The checker
// compares each response field by field against the oldest prediction.
// Tests: refill rules, rate extremes, random traffic with sender bursts and
// receiver stalls, output backpressure, a drain pause and elapsed saturation.
// ----------------------------------------------------------------------------
module tb_token_bucket_rate_limiter;
   import tbrl_pkg::*;

   localparam int TICKS      = 1000;
   localparam int LIMIT      = 400000;
   localparam int MAX_PRINTS = 40;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_mode = MODE_TICK;
   logic [15:0]      req_permits = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_granted;
   logic [15:0]      rsp_tokens_left;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [15:0]      csr_data = '0;

   token_type        bucket_rate;
   token_type        bucket_tokens;
   logic [9:0]       bucket_elapsed;
   rsp_type          pending_decisions[$];

   int               errors = 0;
   int               cycle_count = 0;
   int               rsp_stall_pct = 0;
   int               rsp_hold_left = 0;

   token_bucket_rate_limiter #(
      .TICKS_PER_SECOND(TICKS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_permits    (req_permits),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_granted    (rsp_granted),
      .rsp_tokens_left(rsp_tokens_left),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      if (errors < MAX_PRINTS)
         $display("ERROR @%0t: %s", $time, msg);
      errors++;
   endtask

   task automatic bucket_reset();
      bucket_rate    = RESET_RATE;
      bucket_tokens  = RESET_RATE;
      bucket_elapsed = '0;
   endtask

   task automatic bucket_update(input logic mode, input logic [15:0] permits);
      int unsigned refill;
      int unsigned sum;
      rsp_type     decision;
      if (mode == MODE_TICK) begin
         if (bucket_elapsed < TICKS)
            bucket_elapsed++;
      end else if (permits == 0 || bucket_rate == 0) begin
         decision.granted     = 1'b0;
         decision.tokens_left = bucket_tokens;
         pending_decisions.push_back(decision);
      end else begin
         refill = (int'(unsigned'(bucket_elapsed)) * int'(unsigned'(bucket_rate))) / TICKS;
         if (refill != 0) begin
            sum = int'(unsigned'(bucket_tokens)) + refill;
            bucket_tokens  = (sum > bucket_rate) ? bucket_rate : token_type'(sum);
            bucket_elapsed = '0;
         end
         if (bucket_tokens >= permits) begin
            bucket_tokens    = bucket_tokens - permits;
            decision.granted = 1'b1;
         end else begin
            decision.granted = 1'b0;
         end
         decision.tokens_left = bucket_tokens;
         pending_decisions.push_back(decision);
      end
   endtask

   // Receiver: random stalls, or a long hold-off counted here.
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left--;
      end else if (rsp_stall_pct == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_decisions.size() == 0) begin
            report_error($sformatf("unexpected response granted=%0b tokens_left=%0d",
                                   rsp_granted, rsp_tokens_left));
         end else begin
            want = pending_decisions.pop_front();
            if (rsp_granted !== want.granted)
               report_error($sformatf("granted %0b, expected %0b",
                                      rsp_granted, want.granted));
            if (rsp_tokens_left !== want.tokens_left)
               report_error($sformatf("tokens_left %0d, expected %0d",
                                      rsp_tokens_left, want.tokens_left));
         end
      end
   end

   // Call at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input logic mode, input logic [15:0] permits);
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_permits <= permits;
      do @(posedge clock); while (req_ready !== 1'b1);
      bucket_update(mode, permits);
      @(negedge clock);
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_item(MODE_TICK, 16'($urandom));
   endtask

   task automatic pause_sender(input int n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_decisions.size() != 0);
   endtask

   task automatic load_rate(input token_type rate);
      wait_drain();
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= rate;
      do @(posedge clock); while (csr_ready !== 1'b1);
      bucket_rate   = rate;
      bucket_tokens = rate;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_item(input int tick_pct, input int permit_max);
      int          sel;
      logic [15:0] permits;
      sel = $urandom_range(99);
      if (sel < 4)
         permits = '0;
      else if (sel < 7)
         permits = 16'hFFFF;
      else if (sel < 17)
         permits = 16'($urandom);
      else
         permits = 16'($urandom_range(permit_max));
      send_item(($urandom_range(99) < tick_pct) ? MODE_TICK : MODE_REQUEST, permits);
   endtask

   task automatic run_traffic(input int n, input int tick_pct, input int permit_max,
                              input int gap_max);
      int sent;
      int burst;
      sent = 0;
      while (sent < n) begin
         burst = $urandom_range(24, 1);
         repeat (burst) begin
            if (sent < n) begin
               send_random_item(tick_pct, permit_max);
               sent++;
            end
         end
         if (gap_max > 0 && sent < n)
            pause_sender($urandom_range(gap_max, 1));
      end
   endtask

   task automatic test_refill_rules();
      rsp_stall_pct = 0;
      send_item(MODE_REQUEST, 16'd1);
      send_item(MODE_REQUEST, 16'd0);
      send_item(MODE_REQUEST, 16'hFFFF);
      send_item(MODE_REQUEST, 16'd99);
      // refill rounds to zero: elapsed keeps counting
      send_ticks(5);
      send_item(MODE_REQUEST, 16'd1);
      // refill of one token clears elapsed and drops the remainder
      send_ticks(10);
      send_item(MODE_REQUEST, 16'd1);
      send_item(MODE_REQUEST, 16'd1);
   endtask

   task automatic test_rate_extremes();
      load_rate(16'd0);
      send_item(MODE_REQUEST, 16'd7);
      send_ticks(2);
      send_item(MODE_REQUEST, 16'hFFFF);
      load_rate(16'hFFFF);
      send_item(MODE_REQUEST, 16'hFFFF);
      send_ticks(1);
      send_item(MODE_REQUEST, 16'd1);
      load_rate(16'd1);
      send_item(MODE_REQUEST, 16'd1);
      send_item(MODE_REQUEST, 16'd1);
   endtask

   task automatic test_random_traffic();
      token_type rate;
      int        gaps[3];
      int        stalls[4];
      int        permit_max;
      gaps   = '{0, 3, 8};
      stalls = '{0, 20, 50, 80};
      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 7)
            0: rate = 16'd0;
            1: rate = 16'd1;
            2: rate = 16'hFFFF;
            3: rate = RESET_RATE;
            4: rate = 16'($urandom);
            5: rate = 16'($urandom_range(2000, 1));
            default: rate = 16'($urandom_range(5000, 1000));
         endcase
         load_rate(rate);
         rsp_stall_pct = stalls[$urandom_range(3)];
         permit_max    = int'(unsigned'(rate)) / 4 + 2;
         run_traffic(45, $urandom_range(90, 30), permit_max, gaps[$urandom_range(2)]);
      end
   endtask

   task automatic test_output_backpressure();
      load_rate(16'd2000);
      rsp_stall_pct = 0;
      @(posedge clock);
      rsp_hold_left = 300;
      @(negedge clock);
      repeat (60) send_item(MODE_REQUEST, 16'($urandom_range(80)));
      run_traffic(60, 40, 100, 0);
   endtask

   task automatic test_drain_pause();
      rsp_stall_pct = 50;
      run_traffic(30, 30, 200, 2);
      wait_drain();
      run_traffic(30, 30, 200, 0);
   endtask

   task automatic test_tick_saturation();
      rsp_stall_pct = 0;
      load_rate(16'hFFFF);
      send_item(MODE_REQUEST, 16'hFFFF);
      send_ticks($urandom_range(1100, 1001));
      send_item(MODE_REQUEST, 16'hFFFF);
      send_item(MODE_REQUEST, 16'd1);
   endtask

   initial begin
      bucket_reset();
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_refill_rules();
      test_rate_extremes();
      test_random_traffic();
      test_output_backpressure();
      test_drain_pause();
      test_tick_saturation();
      wait_drain();
      repeat (8) @(negedge clock);
      if (pending_decisions.size() != 0)
         report_error($sformatf("%0d responses never arrived", pending_decisions.size()));
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
